// ===== rtl/core/mbps_pkg.sv =====
package mbps_pkg;

    // Sizes of the scan.
    localparam int MAX_PATTERN = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_WORDS   = 4;
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 6;
    localparam int STEP_W      = 16;
    localparam int ADDR_W      = 64;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0 = 4'd0,
        REG_PATTERN_1 = 4'd1,
        REG_PATTERN_2 = 4'd2,
        REG_PATTERN_3 = 4'd3,
        REG_CARE      = 4'd4,
        REG_LENGTH    = 4'd5,
        REG_STEP      = 4'd6,
        REG_BASE      = 4'd7
    } t_cfg_reg;

    // One streamed byte of the region.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One scan result, given on the last byte of a region.
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_item;

endpackage

// ===== rtl/core/masked_byte_pattern_scan_top.sv =====
// A result passes from the input register through the pending result register (written
// with the scan state update) to the result register, which adds the base address.
// Throughput: one byte per cycle; a byte waits in the input register only when it
// is a last byte and both result registers are held by the consumer.
// Reset (i_rst_n low, synchronous) clears all pipeline valid bits, the scan
// counters and match state, and every configuration register to zero.
module masked_byte_pattern_scan_top
    import mbps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    // Configuration registers.
    logic [PAT_BYTES*8-1:0] r_pattern;
    logic [PAT_BYTES-1:0]   r_care;
    logic [LEN_W-1:0]       r_len;
    logic [STEP_W-1:0]      r_step;
    logic [ADDR_W-1:0]      r_base;

    // Pipeline registers.
    logic                   r_in_valid;
    t_in_item               r_in_item;
    logic                   r_res_valid;
    logic                   r_res_found;
    logic [COUNT_WIDTH-1:0] r_res_offset;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    // Scan state.
    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0] r_bytes_seen;
    logic [COUNT_WIDTH-1:0] n_bytes_seen;
    logic [STEP_W-1:0]      r_phase;
    logic [STEP_W-1:0]      n_phase;
    logic                   r_match_seen;
    logic                   n_match_seen;
    logic [COUNT_WIDTH-1:0] r_match_offset;
    logic [COUNT_WIDTH-1:0] n_match_offset;

    // Handshake control.
    logic out_free;
    logic res_free;
    logic res_move;
    logic in_proc;

    // Scan datapath.
    logic                   counted;
    logic                   len_ok;
    logic                   try_cand;
    logic                   win_match;
    logic [COUNT_WIDTH-1:0] seen_next;
    logic [STEP_W-1:0]      stride;
    logic [STEP_W:0]        phase_inc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign res_free   = !r_res_valid || out_free;
    assign res_move   = r_res_valid && out_free;
    assign in_proc    = r_in_valid && (!r_in_item.last_byte || res_free);
    assign o_in_ready = !r_in_valid || in_proc;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_care    <= '0;
            r_len     <= '0;
            r_step    <= '0;
            r_base    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
                    r_pattern[WORD_W*i_cfg_index[1:0] +: WORD_W] <= i_cfg_data;
                end
                REG_CARE:   r_care <= i_cfg_data[PAT_BYTES-1:0];
                REG_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                REG_STEP:   r_step <= i_cfg_data[STEP_W-1:0];
                REG_BASE:   r_base <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: takes a transfer whenever the stage drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // Window shift with the new byte in entry 0.
    always_comb begin
        n_win[0] = r_in_item.data_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    // Masked compare of the newest len bytes against the pattern.
    always_comb begin
        logic [7:0] sel;
        win_match = 1'b1;
        for (int i = 0; i < PAT_BYTES; i++) begin
            sel = '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (int'(r_len) == i + j + 1) begin
                    sel = n_win[j];
                end
            end
            if (i < int'(r_len) && r_care[i] && sel != r_pattern[8*i +: 8]) begin
                win_match = 1'b0;
            end
        end
    end

    // Candidate bookkeeping for the byte in the input register.
    assign counted   = r_bytes_seen != '1;
    assign seen_next = counted ? r_bytes_seen + 1'b1 : r_bytes_seen;
    assign len_ok    = r_len != '0 && int'(r_len) <= PAT_BYTES
                       && int'(r_len) <= MAX_PATTERN;
    assign try_cand  = counted && len_ok && seen_next >= COUNT_WIDTH'(r_len);
    assign stride    = (r_step != '0) ? r_step : STEP_W'(r_len);
    assign phase_inc = {1'b0, r_phase} + 1'b1;

    always_comb begin
        n_bytes_seen   = seen_next;
        n_phase        = r_phase;
        n_match_seen   = r_match_seen;
        n_match_offset = r_match_offset;
        if (try_cand) begin
            if (r_phase == '0 && !r_match_seen && win_match) begin
                n_match_seen   = 1'b1;
                n_match_offset = seen_next - COUNT_WIDTH'(r_len);
            end
            n_phase = (phase_inc >= {1'b0, stride}) ? '0 : phase_inc[STEP_W-1:0];
        end
    end

    // Scan state update; a last byte starts the next region from zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen   <= '0;
            r_phase        <= '0;
            r_match_seen   <= 1'b0;
            r_match_offset <= '0;
        end else if (in_proc) begin
            if (r_in_item.last_byte) begin
                r_bytes_seen   <= '0;
                r_phase        <= '0;
                r_match_seen   <= 1'b0;
                r_match_offset <= '0;
            end else begin
                r_bytes_seen   <= n_bytes_seen;
                r_phase        <= n_phase;
                r_match_seen   <= n_match_seen;
                r_match_offset <= n_match_offset;
            end
        end
    end

    // Window entries beyond the bytes seen are never compared, so no clear.
    always_ff @(posedge i_clk) begin
        if (in_proc) begin
            r_win <= n_win;
        end
    end

    // Pending result of a finished region.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_free) begin
            r_res_valid <= in_proc && r_in_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_proc && r_in_item.last_byte) begin
            r_res_found  <= n_match_seen;
            r_res_offset <= n_match_offset;
        end
    end

    // Result register with the base address added.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_move) begin
            r_out_item.found         <= r_res_found;
            r_out_item.match_address <= r_res_found
                                        ? r_base + ADDR_W'(r_res_offset) : '0;
        end
    end

    // A result without a match carries a zero address.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.found |-> r_out_item.match_address == '0)
        else $error("result without match has a nonzero address");

    // The match offset stays zero until a match is recorded.
    a_offset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_match_seen |-> r_match_offset == '0)
        else $error("match offset set without a match");

    // A match needs at least one byte of the region.
    a_match_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_seen |-> r_bytes_seen != '0)
        else $error("match recorded in an empty region");

    // A pending result always reaches the result register once it moves.
    a_result_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_move |=> r_out_valid)
        else $error("pending result lost on its way out");

endmodule
